### sv/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
package tccw_pkg;

  // Fixed field widths of the stream words
  localparam int CHAR_W  = 8;
  localparam int ADDR_IW = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int CMD_W   = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Command codes carried in tuser
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Control characters
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam int TAB_STEP = 8;

  // Cell value after reset: space with attribute 07h
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
  localparam logic [7:0]        RESET_ATTR = 8'h07;

  // Configuration register indexes
  localparam logic REG_TEXT_ATTR  = 1'b0;
  localparam logic REG_OUT_DISABL = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  typedef enum logic [3:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_BACK,
    OP_CLEAR,
    OP_READ,
    OP_IGNORE,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [CHAR_W-1:0]   chr;
    logic [ADDR_IW-1:0]  addr;
    logic                addr_ok;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ_WAIT,
    ST_SCROLL_COPY,
    ST_SCROLL_BLANK,
    ST_CLEAR
  } st_e;

endpackage

### sv/tccw_front.sv
// Front end: accepts command words and decodes them into queue entries.
module tccw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tccw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic [tccw_pkg::CMD_W-1:0]        s_axis_tuser,
  input  logic                              disabled_i,
  input  logic                              init_done_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output tccw_pkg::entry_t                  q_entry_o
);
  import tccw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;

  logic [CHAR_W-1:0]  chr;
  logic [ADDR_IW-1:0] addr;
  op_e                op;

  assign chr  = s_axis_tdata[CHAR_W-1:0];
  assign addr = s_axis_tdata[CHAR_W+ADDR_IW-1:CHAR_W];

  assign s_axis_tready = init_done_i && !q_full_i;
  assign q_push_o      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    op = OP_NOP;
    case (s_axis_tuser)
      CMD_PUT: begin
        if (disabled_i) begin
          op = OP_IGNORE;
        end else begin
          case (chr)
            CHAR_NL:  op = OP_NEWLINE;
            CHAR_CR:  op = OP_RETURN;
            CHAR_TAB: op = OP_TAB;
            CHAR_BS:  op = OP_BACK;
            default:  op = OP_PUT;
          endcase
        end
      end
      CMD_CLEAR: op = disabled_i ? OP_IGNORE : OP_CLEAR;
      CMD_READ:  op = OP_READ;
      default:   op = OP_NOP;
    endcase
  end

  always_comb begin
    q_entry_o.op      = op;
    q_entry_o.chr     = chr;
    q_entry_o.addr    = addr;
    q_entry_o.addr_ok = (32'(addr) < CELL_COUNT);
  end

endmodule

### sv/tccw_fifo.sv
// Two-entry queue between the decode front and the execute back.
module tccw_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tccw_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output tccw_pkg::entry_t  entry_o
);
  import tccw_pkg::*;

  entry_t               mem_q [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == Q_CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### sv/tccw_back.sv
// Back end: cursor, screen store, scroll/clear sweeps and the result register.
module tccw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [7:0]                    attr_i,
  input  logic                          q_valid_i,
  input  tccw_pkg::entry_t              q_entry_i,
  output logic                          q_pop_o,
  output logic                          init_done_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tccw_pkg::POS_W-1:0]    out_pos_o,
  output logic [tccw_pkg::CELL_W-1:0]   out_cell_o,
  output logic                          out_ign_o
);
  import tccw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [COL_W:0]    TAB_ADD   = (COL_W+1)'(TAB_STEP);
  localparam logic [COL_W:0]    TAB_MASK  = ~((COL_W+1)'(TAB_STEP - 1));

  // Screen store
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  st_e               state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic              rd_ok_q, rd_ok_d;
  logic              cp_wr_q, cp_wr_d;
  logic [ADDR_W-1:0] cp_dst_q, cp_dst_d;
  logic              out_valid_q, out_valid_d;
  logic [POS_W-1:0]  out_pos_q;
  logic [CELL_W-1:0] out_cell_q;
  logic              out_ign_q;

  logic              out_free;
  logic              load;
  logic              adv_row;
  logic [CELL_W-1:0] res_cell;
  logic              res_ign;
  logic [COL_W:0]    tab_col;
  logic [CELL_W-1:0] blank;

  assign out_free = !out_valid_q || out_ready_i;
  assign tab_col  = ({1'b0, col_q} + TAB_ADD) & TAB_MASK;
  assign blank    = {attr_i, CHAR_SPACE};

  assign init_done_o = (state_q != ST_INIT);
  assign out_valid_o = out_valid_q;
  assign out_pos_o   = out_pos_q;
  assign out_cell_o  = out_cell_q;
  assign out_ign_o   = out_ign_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    col_d     = col_q;
    row_d     = row_q;
    pos_d     = pos_q;
    rd_ok_d   = rd_ok_q;
    cp_wr_d   = 1'b0;
    cp_dst_d  = cp_dst_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    q_pop_o   = 1'b0;
    load      = 1'b0;
    adv_row   = 1'b0;
    res_cell  = '0;
    res_ign   = 1'b0;

    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[ADDR_W-1:0];
        mem_wdata = RESET_CELL;
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_entry_i.op)
            OP_PUT: begin
              mem_we    = 1'b1;
              mem_waddr = pos_q;
              mem_wdata = {attr_i, q_entry_i.chr};
              load      = 1'b1;
              if (col_q == COL_W'(COLUMNS - 1)) begin
                adv_row = 1'b1;
              end else begin
                col_d = col_q + 1'b1;
                pos_d = pos_q + 1'b1;
              end
            end
            OP_NEWLINE: begin
              load    = 1'b1;
              adv_row = 1'b1;
            end
            OP_RETURN: begin
              load  = 1'b1;
              col_d = '0;
              pos_d = pos_q - ADDR_W'(col_q);
            end
            OP_TAB: begin
              load = 1'b1;
              if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                adv_row = 1'b1;
              end else begin
                col_d = tab_col[COL_W-1:0];
                pos_d = pos_q + ADDR_W'(tab_col - {1'b0, col_q});
              end
            end
            OP_BACK: begin
              load = 1'b1;
              if (col_q != '0) begin
                col_d = col_q - 1'b1;
                pos_d = pos_q - 1'b1;
              end
            end
            OP_CLEAR: begin
              state_d = ST_CLEAR;
              cnt_d   = '0;
              col_d   = '0;
              row_d   = '0;
              pos_d   = '0;
            end
            OP_READ: begin
              mem_re    = q_entry_i.addr_ok;
              mem_raddr = ADDR_W'(q_entry_i.addr);
              rd_ok_d   = q_entry_i.addr_ok;
              state_d   = ST_READ_WAIT;
            end
            OP_IGNORE: begin
              load    = 1'b1;
              res_ign = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase

          // next row, or scroll when already on the last one
          if (adv_row) begin
            col_d = '0;
            if (row_q == ROW_W'(ROWS - 1)) begin
              load    = 1'b0;
              pos_d   = LAST_BASE;
              cnt_d   = CNT_W'(COLUMNS);
              state_d = ST_SCROLL_COPY;
            end else begin
              row_d = row_q + 1'b1;
              pos_d = pos_q - ADDR_W'(col_q) + COLS_A;
            end
          end
        end
      end

      ST_READ_WAIT: begin
        load     = 1'b1;
        res_cell = rd_ok_q ? rdata_q : '0;
        state_d  = ST_IDLE;
      end

      ST_SCROLL_COPY: begin
        // read cell n, write it one row up in the next cycle
        if (cp_wr_q) begin
          mem_we    = 1'b1;
          mem_waddr = cp_dst_q;
          mem_wdata = rdata_q;
        end
        if (cnt_q == CNT_W'(CELL_COUNT)) begin
          cnt_d   = CNT_W'(CELL_COUNT - COLUMNS);
          state_d = ST_SCROLL_BLANK;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cnt_q[ADDR_W-1:0];
          cp_wr_d   = 1'b1;
          cp_dst_d  = ADDR_W'(cnt_q - CNT_W'(COLUMNS));
          cnt_d     = cnt_q + 1'b1;
        end
      end

      ST_SCROLL_BLANK, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[ADDR_W-1:0];
        mem_wdata = blank;
        if (cnt_q == CNT_W'(CELL_COUNT - 1)) begin
          load    = 1'b1;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = (out_valid_q && !out_ready_i) || load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      pos_q       <= '0;
      rd_ok_q     <= 1'b0;
      cp_wr_q     <= 1'b0;
      cp_dst_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pos_q       <= pos_d;
      rd_ok_q     <= rd_ok_d;
      cp_wr_q     <= cp_wr_d;
      cp_dst_q    <= cp_dst_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_pos_q  <= POS_W'(pos_d);
      out_cell_q <= res_cell;
      out_ign_q  <= res_ign;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

endmodule

### sv/text_console_cell_writer_core.sv
// Top level of the text console cell writer: config registers and stream ports.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata: char, cell address; tuser: cmd
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata: cursor, cell; tuser: ignored
//  cfg       in   cfg_we_i (no back-pressure)     cfg_index_i, cfg_wdata_i
//
// Plain characters, tab, backspace, newline without scroll and ignored commands
// are handled in ST_IDLE; a read also passes ST_READ_WAIT (registered store read).
// A scroll copies through the single store port pair (ST_SCROLL_COPY), then blanks
// the bottom row (ST_SCROLL_BLANK); a clear blanks every cell (ST_CLEAR).
// After reset the store is swept to 0720h; s_axis_tready stays low until the sweep
// ends, config writes are taken throughout.
// A stalled m_axis holds its word; the two-entry queue keeps taking words until
// full, and the back end only starts a command once the result register is free.
module text_console_cell_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write port
  input  logic                               cfg_we_i,
  input  logic                               cfg_index_i,
  input  logic [7:0]                         cfg_wdata_i,
  // command words
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tccw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] char_code, [18:8] cell_address
  input  logic [tccw_pkg::CMD_W-1:0]         s_axis_tuser,  // [1:0] cmd
  // result words
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tccw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [10:0] cursor_position, [26:11] cell_value
  output logic                               m_axis_tuser   // [0] ignored
);
  import tccw_pkg::*;

  logic [7:0]        attr_q;
  logic              dis_q;
  logic              init_done;
  logic              q_full, q_push, q_pop, q_valid;
  entry_t            q_in, q_out;
  logic [POS_W-1:0]  out_pos;
  logic [CELL_W-1:0] out_cell;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
      dis_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEXT_ATTR:  attr_q <= cfg_wdata_i;
        REG_OUT_DISABL: dis_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .disabled_i    (dis_q),
    .init_done_i   (init_done),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  tccw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .attr_i      (attr_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .init_done_o (init_done),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pos_o   (out_pos),
    .out_cell_o  (out_cell),
    .out_ign_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - POS_W - CELL_W)'(0), out_cell, out_pos};

endmodule

### sv/tccw_checker.sv
// Port-level checks for the text console cell writer, bound to the top level.
module tccw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  localparam int CELL_COUNT = COLUMNS * ROWS;

  // result word stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // stalled result word does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // cursor of an offered result word inside the screen (not checked above 2048 cells)
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (CELL_COUNT > 2048) || (32'(m_axis_tdata[10:0]) < CELL_COUNT))
    else $error("cursor position outside screen");

  // an ignored command never carries cell data
  a_ign_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[26:11] == 16'h0000))
    else $error("ignored command returned a cell");

  // handshake lines are always known out of reset
  a_known_handshake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready}))
    else $error("handshake line unknown");

endmodule

bind text_console_cell_writer_core tccw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
